>>> rtl/core/lfpd_pkg.sv
// ----------------------------------------------------------------------------
// lfpd_pkg
// Types and constants shared by the line follower PD speed control block.
// ----------------------------------------------------------------------------
package lfpd_pkg;

  // sequencer states, one-hot
  typedef enum logic [9:0] {
    ST_IDLE    = 10'b00_0000_0001,
    ST_DIV_POS = 10'b00_0000_0010,
    ST_ERR     = 10'b00_0000_0100,
    ST_MUL_BRK = 10'b00_0000_1000,
    ST_MUL_P   = 10'b00_0001_0000,
    ST_MUL_D   = 10'b00_0010_0000,
    ST_PD      = 10'b00_0100_0000,
    ST_DIV_LD  = 10'b00_1000_0000,
    ST_DIV_INT = 10'b01_0000_0000,
    ST_FIN     = 10'b10_0000_0000
  } lfpd_state_t;

  // configuration register indexes
  localparam logic [2:0] REG_GAIN_P    = 3'd0;
  localparam logic [2:0] REG_GAIN_D    = 3'd1;
  localparam logic [2:0] REG_BRAKE     = 3'd2;
  localparam logic [2:0] REG_TOP       = 3'd3;
  localparam logic [2:0] REG_CURVE     = 3'd4;
  localparam logic [2:0] REG_STRAIGHT  = 3'd5;
  localparam logic [2:0] REG_RAMP      = 3'd6;
  localparam logic [2:0] REG_SPIN      = 3'd7;

  localparam int CENTER_POS  = 3500;
  localparam int POS_SCALE   = 1000;
  localparam int DRIVE_MAX   = 100;
  localparam int BRAKE_FLOOR = -30;

  // serial divider: dividend and divisor widths
  localparam int DVD_W = 19;
  localparam int DVS_W = 12;

endpackage

>>> rtl/core/line_follower_pd_speed_control.sv
// ----------------------------------------------------------------------------
// line_follower_pd_speed_control
// PD steering and speed controller for an 8-sensor line follower.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one sensor word per sample (bit i = sensor i sees the line).
//   out_* : one result word per sample; tdata = left drive (low byte),
//           right drive (high byte), both signed; tuser = line lost.
//   cfg_* : register writes by index; they take effect at once, so write
//           only while no sample is in flight.
// Timing: on a curve a sample takes two passes of the shared restoring
//   divider and four passes of the shared multiplier, plus setup; on a
//   straight track the second division is skipped. With no line the
//   sequencer goes straight to the final step. in_tready is high only
//   while the sequencer is idle, which it enters as each result is
//   loaded, so a new sample is taken only once the last one is through;
//   a sample is taken while a result still waits.
// Stall: a finished result waits in the final step until the output
//   register is free; nothing is dropped.
// Reset: rst_n (synchronous, active low) loads the register defaults,
//   clears the line-seen flag, sets the last position to center and clears
//   the error history and base speed.
// ----------------------------------------------------------------------------
module line_follower_pd_speed_control (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] sensor_bits
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [7:0] left_drive, [15:8] right_drive
  output logic        out_tuser,  // [0] line_lost
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import lfpd_pkg::*;

  // configuration registers
  logic [15:0] gain_p_r, gain_d_r, brake_r;
  logic [6:0]  top_r, curve_r, ramp_r, spin_r;
  logic [11:0] straight_r;

  // controller state
  logic               seen_r;
  logic [12:0]        last_pos_r;
  logic signed [12:0] prior_r;
  logic signed [7:0]  base_r;

  // per-sample working registers
  lfpd_state_t        state_r;
  logic               lost_r;
  logic signed [12:0] err_r;
  logic signed [13:0] delta_r;
  logic [11:0]        abs_err_r;
  logic [17:0]        penalty_r;
  logic signed [32:0] pd_r;
  logic               is_straight_r;
  logic               neg_r;

  // shared multiplier
  logic signed [16:0] mul_a;
  logic signed [14:0] mul_b;
  logic signed [31:0] prod_r;

  // shared divider
  logic [DVD_W-1:0] dvd_r;
  logic [DVS_W-1:0] dvs_r;
  logic [DVS_W-1:0] rem_r;
  logic [4:0]       dcnt_r;
  logic [DVS_W:0]   div_sh;
  logic             div_bit;

  // output register
  logic        out_valid_r;
  logic [15:0] out_data_r;
  logic        out_user_r;

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  logic in_fire, out_free;
  assign in_fire  = in_tvalid && in_tready;
  assign out_free = !out_valid_r || out_tready;

  // centroid terms of the incoming word
  logic [4:0]  idx_sum;
  logic [3:0]  bit_cnt;
  logic [14:0] pos_dvd;
  always_comb begin
    idx_sum = '0;
    bit_cnt = '0;
    for (int i = 0; i < 8; i++) begin
      if (in_tdata[i]) begin
        idx_sum = idx_sum + 5'(i);
        bit_cnt = bit_cnt + 4'd1;
      end
    end
    pos_dvd = 15'(idx_sum) * 15'(POS_SCALE);
  end

  // divider step
  assign div_sh  = {rem_r, dvd_r[DVD_W-1]};
  assign div_bit = (div_sh >= {1'b0, dvs_r});

  // error terms after the position division
  logic [12:0]        pos_w;
  logic signed [12:0] err_w;
  logic signed [12:0] prior_eff;
  logic signed [13:0] delta_w;
  assign pos_w     = dvd_r[12:0];
  assign err_w     = 13'($signed({1'b0, pos_w}) - 14'sd3500);
  assign prior_eff = seen_r ? prior_r : err_w;
  assign delta_w   = 14'(err_w) - 14'(prior_eff);

  logic [13:0] delta_mag;
  assign delta_mag = delta_r[13] ? 14'(-delta_r) : 14'(delta_r);

  // interpolation operands
  logic [11:0]       above_w, span_w;
  logic signed [7:0] diff_w;
  assign above_w = abs_err_r - straight_r;
  assign span_w  = 12'(CENTER_POS) - straight_r;
  assign diff_w  = $signed({1'b0, top_r}) - $signed({1'b0, curve_r});

  // multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      ST_MUL_BRK: begin
        mul_a = $signed({1'b0, brake_r});
        mul_b = $signed({1'b0, delta_mag});
      end
      ST_MUL_P: begin
        mul_a = $signed({1'b0, gain_p_r});
        mul_b = 15'(err_r);
      end
      ST_MUL_D: begin
        mul_a = $signed({1'b0, gain_d_r});
        mul_b = 15'(delta_r);
      end
      ST_PD: begin
        mul_a = $signed({5'b0, above_w});
        mul_b = 15'(diff_w);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // final step: target, base speed and wheel commands
  logic signed [19:0] quot_s, tgt_i, tgt_b, base_ext, ramp_sum, base_new;
  logic signed [32:0] pd_mag;
  logic signed [22:0] corr, left_w, right_w;
  logic [7:0]         left_q, right_q, base_q;
  logic signed [7:0]  spin_s;

  function automatic logic [7:0] sat_drive(input logic signed [22:0] v);
    if (v > 23'sd100) return 8'd100;
    else if (v < -23'sd100) return 8'(-100);
    else return v[7:0];
  endfunction

  always_comb begin
    quot_s = neg_r ? -$signed({1'b0, dvd_r}) : $signed({1'b0, dvd_r});
    if (is_straight_r) begin
      tgt_i = 20'(top_r);
    end else begin
      tgt_i = $signed({13'b0, top_r}) - quot_s;
      if (tgt_i < $signed({13'b0, curve_r})) tgt_i = 20'(curve_r);
    end
    tgt_b = tgt_i - $signed({2'b0, penalty_r});
    if (tgt_b < 20'(BRAKE_FLOOR)) tgt_b = 20'(BRAKE_FLOOR);
    base_ext = 20'(base_r);
    ramp_sum = base_ext + $signed({13'b0, ramp_r});
    if (tgt_b > base_ext) begin
      base_new = (ramp_sum > tgt_b) ? tgt_b : ramp_sum;
    end else begin
      base_new = tgt_b;
    end
    base_q  = base_new[7:0];
    pd_mag  = pd_r[32] ? -pd_r : pd_r;
    corr    = pd_r[32] ? -$signed(23'(pd_mag >>> 12)) : $signed(23'(pd_mag >>> 12));
    left_w  = 23'($signed(base_q)) + corr;
    right_w = 23'($signed(base_q)) - corr;
    left_q  = sat_drive(left_w);
    right_q = sat_drive(right_w);
    spin_s  = $signed({1'b0, spin_r});
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_p_r   <= 16'd164;
      gain_d_r   <= 16'd1024;
      brake_r    <= 16'd164;
      top_r      <= 7'd100;
      curve_r    <= 7'd30;
      straight_r <= 12'd500;
      ramp_r     <= 7'd5;
      spin_r     <= 7'd15;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_GAIN_P:   gain_p_r   <= cfg_data;
        REG_GAIN_D:   gain_d_r   <= cfg_data;
        REG_BRAKE:    brake_r    <= cfg_data;
        REG_TOP:      top_r      <= cfg_data[6:0];
        REG_CURVE:    curve_r    <= cfg_data[6:0];
        REG_STRAIGHT: straight_r <= cfg_data[11:0];
        REG_RAMP:     ramp_r     <= cfg_data[6:0];
        REG_SPIN:     spin_r     <= cfg_data[6:0];
        default:      ;
      endcase
    end
  end

  // shared multiplier, registered product
  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      seen_r      <= 1'b0;
      last_pos_r  <= 13'd3500;
      prior_r     <= '0;
      base_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // the final step reloads the output word itself
      if (out_valid_r && out_tready && (state_r != ST_FIN)) out_valid_r <= 1'b0;
      case (state_r)
        ST_IDLE: begin
          if (in_fire) begin
            lost_r <= (in_tdata == 8'd0);
            if (in_tdata == 8'd0) begin
              state_r <= ST_FIN;
            end else begin
              dvd_r   <= DVD_W'(pos_dvd);
              dvs_r   <= DVS_W'(bit_cnt);
              rem_r   <= '0;
              dcnt_r  <= 5'(DVD_W - 1);
              state_r <= ST_DIV_POS;
            end
          end
        end
        ST_DIV_POS, ST_DIV_INT: begin
          rem_r  <= div_bit ? DVS_W'(div_sh - {1'b0, dvs_r}) : div_sh[DVS_W-1:0];
          dvd_r  <= {dvd_r[DVD_W-2:0], div_bit};
          dcnt_r <= dcnt_r - 5'd1;
          if (dcnt_r == 5'd0) state_r <= (state_r == ST_DIV_POS) ? ST_ERR : ST_FIN;
        end
        ST_ERR: begin
          err_r      <= err_w;
          delta_r    <= delta_w;
          abs_err_r  <= err_w[12] ? 12'(-err_w) : 12'(err_w);
          last_pos_r <= pos_w;
          if (!seen_r) begin
            seen_r  <= 1'b1;
            prior_r <= err_w;
            base_r  <= $signed({1'b0, curve_r});
          end
          state_r <= ST_MUL_BRK;
        end
        ST_MUL_BRK: state_r <= ST_MUL_P;
        ST_MUL_P: begin
          penalty_r <= 18'(prod_r >>> 12);
          state_r   <= ST_MUL_D;
        end
        ST_MUL_D: begin
          pd_r    <= 33'(prod_r);
          state_r <= ST_PD;
        end
        ST_PD: begin
          pd_r          <= pd_r + 33'(prod_r);
          is_straight_r <= (abs_err_r <= straight_r);
          state_r       <= (abs_err_r <= straight_r) ? ST_FIN : ST_DIV_LD;
        end
        ST_DIV_LD: begin
          neg_r   <= prod_r[31];
          dvd_r   <= prod_r[31] ? DVD_W'(-prod_r) : DVD_W'(prod_r);
          dvs_r   <= span_w;
          rem_r   <= '0;
          dcnt_r  <= 5'(DVD_W - 1);
          state_r <= ST_DIV_INT;
        end
        ST_FIN: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_user_r  <= lost_r;
            if (lost_r) begin
              if (seen_r) begin
                base_r <= '0;
                if (last_pos_r < 13'd3500) begin
                  out_data_r <= {sat_drive(23'(spin_s)), sat_drive(-23'(spin_s))};
                end else begin
                  out_data_r <= {sat_drive(-23'(spin_s)), sat_drive(23'(spin_s))};
                end
              end else begin
                out_data_r <= '0;
              end
            end else begin
              base_r     <= $signed(base_q);
              prior_r    <= err_r;
              out_data_r <= {right_q, left_q};
            end
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

endmodule

>>> dv/lfpd_checker.sv
// ----------------------------------------------------------------------------
// lfpd_checker
// Watches the sensor and drive streams and the register port of the line
// follower PD speed controller, predicts each drive word from its own copy
// of the controller state and compares it field by field.
// ----------------------------------------------------------------------------
module lfpd_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [7:0]  in_tdata,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [15:0] out_tdata,
  input  logic        out_tuser,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  output int          fail_count,
  output int          pending_count
);
  timeunit 1ns;
  timeprecision 1ps;
  import lfpd_pkg::*;

  typedef struct packed {
    logic signed [7:0] left_drive;
    logic signed [7:0] right_drive;
    logic              line_lost;
  } drive_word_t;

  drive_word_t drive_queue[$];

  // controller registers
  longint gain_p, gain_d, gain_brk;
  longint spd_top, spd_curve, lim_straight, step_ramp, spd_spin;
  // controller state
  bit     seen;
  longint last_pos, prev_err, base_spd;

  function automatic longint clamp_drive(longint v);
    if (v > DRIVE_MAX) return DRIVE_MAX;
    if (v < -DRIVE_MAX) return -DRIVE_MAX;
    return v;
  endfunction

  function automatic longint mag(longint v);
    return v < 0 ? -v : v;
  endfunction

  // one sample through the steering law
  function automatic drive_word_t steer_sample(logic [7:0] bits);
    drive_word_t w;
    longint lft, rgt, sum, cnt, pos, err, dlt, aerr, tgt, pen, pd, corr;
    lft = 0;
    rgt = 0;
    w.line_lost = (bits == 0);
    if (bits == 0) begin
      if (seen) begin
        base_spd = 0;
        if (last_pos < CENTER_POS) begin
          lft = -spd_spin;
          rgt = spd_spin;
        end else begin
          lft = spd_spin;
          rgt = -spd_spin;
        end
      end
    end else begin
      sum = 0;
      cnt = 0;
      for (int i = 0; i < 8; i++)
        if (bits[i]) begin
          sum += i * POS_SCALE;
          cnt++;
        end
      pos = sum / cnt;
      err = pos - CENTER_POS;
      if (!seen) begin
        prev_err = err;
        base_spd = spd_curve;
        seen = 1;
      end
      last_pos = pos;
      aerr = mag(err);
      dlt = err - prev_err;
      if (aerr <= lim_straight) begin
        tgt = spd_top;
      end else begin
        tgt = spd_top - ((aerr - lim_straight) * (spd_top - spd_curve))
              / (CENTER_POS - lim_straight);
        if (tgt < spd_curve) tgt = spd_curve;
      end
      pen = (gain_brk * mag(dlt)) >>> 12;
      tgt = (tgt - pen < BRAKE_FLOOR) ? BRAKE_FLOOR : tgt - pen;
      if (tgt > base_spd) begin
        base_spd += step_ramp;
        if (base_spd > tgt) base_spd = tgt;
      end else begin
        base_spd = tgt;
      end
      pd = gain_p * err + gain_d * dlt;
      corr = (pd < 0) ? -(mag(pd) >>> 12) : (mag(pd) >>> 12);
      prev_err = err;
      lft = base_spd + corr;
      rgt = base_spd - corr;
    end
    w.left_drive = 8'(clamp_drive(lft));
    w.right_drive = 8'(clamp_drive(rgt));
    return w;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %0s: got %0d expected %0d at %0t", what, got, want, $realtime);
    fail_count++;
  endtask

  always @(posedge clk) begin
    drive_word_t exp_w;
    if (!rst_n) begin
      gain_p = 164; gain_d = 1024; gain_brk = 164;
      spd_top = 100; spd_curve = 30; lim_straight = 500;
      step_ramp = 5; spd_spin = 15;
      seen = 0; last_pos = CENTER_POS; prev_err = 0; base_spd = 0;
      drive_queue.delete();
      fail_count = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_GAIN_P:   gain_p = cfg_data;
          REG_GAIN_D:   gain_d = cfg_data;
          REG_BRAKE:    gain_brk = cfg_data;
          REG_TOP:      spd_top = cfg_data[6:0];
          REG_CURVE:    spd_curve = cfg_data[6:0];
          REG_STRAIGHT: lim_straight = cfg_data[11:0];
          REG_RAMP:     step_ramp = cfg_data[6:0];
          REG_SPIN:     spd_spin = cfg_data[6:0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) drive_queue.push_back(steer_sample(in_tdata));
      if (out_tvalid && out_tready) begin
        if (drive_queue.size() == 0) begin
          report_mismatch("unexpected drive word", out_tdata, 0);
        end else begin
          exp_w = drive_queue.pop_front();
          if ($signed(out_tdata[7:0]) != exp_w.left_drive)
            report_mismatch("left_drive", $signed(out_tdata[7:0]), exp_w.left_drive);
          if ($signed(out_tdata[15:8]) != exp_w.right_drive)
            report_mismatch("right_drive", $signed(out_tdata[15:8]), exp_w.right_drive);
          if (out_tuser != exp_w.line_lost)
            report_mismatch("line_lost", out_tuser, exp_w.line_lost);
        end
      end
    end
    pending_count = drive_queue.size();
  end

endmodule

>>> dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Stimulus for the line follower PD speed controller: directed sensor words,
// then random track runs with line losses, over several register settings,
// with random gaps and stalls on both streams; the checker gives the verdict.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import lfpd_pkg::*;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;   // [7:0] sensor_bits
  logic        out_tvalid;
  logic        out_tready;
  logic [15:0] out_tdata;  // [7:0] left_drive, [15:8] right_drive
  logic        out_tuser;  // [0] line_lost
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [15:0] cfg_data;
  int          fail_count;
  int          pending_count;
  bit          hold_long;
  bit          hold_done;
  int          quiet_cycles;

  localparam int QUIET_LIMIT = 20000;

  line_follower_pd_speed_control dut (.*);

  lfpd_checker chk (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // send one sensor word after a random gap
  task automatic send_word(logic [7:0] bits);
    repeat ($urandom_range(0, 14)) @(negedge clk);
    in_tvalid = 1;
    in_tdata = bits;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
    in_tvalid = 0;
  endtask

  task automatic write_reg(logic [2:0] idx, logic [15:0] val);
    cfg_we = 1;
    cfg_index = idx;
    cfg_data = val;
    @(negedge clk);
    cfg_we = 0;
  endtask

  task automatic drain;
    while (pending_count != 0) @(negedge clk);
    repeat (60) @(negedge clk);
  endtask

  // a track run: a line at a random spot drifting either way, with some random words, then maybe lost
  task automatic track_run;
    int p, w;
    p = $urandom_range(0, 7);
    repeat ($urandom_range(3, 20)) begin
      if ($urandom_range(0, 9) == 0) begin
        send_word(8'($urandom_range(0, 255)));
      end else begin
        w = $urandom_range(1, 3);
        send_word(8'(((1 << w) - 1) << p));
        if ($urandom_range(0, 1)) p = (p < 7) ? p + 1 : p;
        else p = (p > 0) ? p - 1 : p;
      end
    end
    if ($urandom_range(0, 2) == 0) repeat ($urandom_range(1, 4)) send_word(8'h00);
  endtask

  task automatic random_settings;
    write_reg(REG_GAIN_P,
              16'($urandom_range(0, 2) == 0 ? $urandom : $urandom_range(0, 2000)));
    write_reg(REG_GAIN_D,
              16'($urandom_range(0, 2) == 0 ? $urandom : $urandom_range(0, 4000)));
    write_reg(REG_BRAKE,
              16'($urandom_range(0, 2) == 0 ? $urandom : $urandom_range(0, 600)));
    write_reg(REG_TOP, 16'($urandom_range(0, 127)));
    write_reg(REG_CURVE, 16'($urandom_range(0, 127)));
    write_reg(REG_STRAIGHT, 16'($urandom_range(0, 4095)));
    write_reg(REG_RAMP, 16'($urandom_range(0, 127)));
    write_reg(REG_SPIN, 16'($urandom_range(0, 127)));
  endtask

  // receiver: random stalls, one long hold-off when asked
  initial begin
    out_tready = 0;
    hold_done = 0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_long && !hold_done) begin
        out_tready = 0;
        repeat (400) @(negedge clk);
        hold_done = 1;
      end
      if ($urandom_range(0, 3) == 0) begin
        out_tready = 0;
        repeat ($urandom_range(0, 14)) @(negedge clk);
      end
      out_tready = 1;
      repeat ($urandom_range(0, 6)) @(negedge clk);
    end
  end

  // watchdog on accepted words
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || !rst_n) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > QUIET_LIMIT) begin
      $display("** line_follower_pd_speed_control: FAILED **");
      $finish;
    end
  end

  initial begin
    rst_n = 0;
    in_tvalid = 0;
    in_tdata = 0;
    cfg_we = 0;
    cfg_index = 0;
    cfg_data = 0;
    hold_long = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1;

    // lost before first sight, then first sight, then each single sensor
    send_word(8'h00);
    send_word(8'h00);
    send_word(8'h18);
    for (int i = 0; i < 8; i++) send_word(8'(1 << i));
    send_word(8'h00);
    send_word(8'h01);
    send_word(8'h00);
    send_word(8'hFF);
    send_word(8'h81);
    send_word(8'hAA);
    send_word(8'h55);
    drain();

    // extremes: all-straight limit, huge gains, curve above top
    write_reg(REG_GAIN_P, 16'hFFFF);
    write_reg(REG_GAIN_D, 16'hFFFF);
    write_reg(REG_BRAKE, 16'hFFFF);
    write_reg(REG_TOP, 16'd127);
    write_reg(REG_CURVE, 16'd0);
    write_reg(REG_STRAIGHT, 16'd4095);
    write_reg(REG_RAMP, 16'd127);
    write_reg(REG_SPIN, 16'd127);
    send_word(8'h01); send_word(8'h80); send_word(8'h00); send_word(8'h18);
    drain();
    write_reg(REG_GAIN_P, 16'd0);
    write_reg(REG_GAIN_D, 16'd0);
    write_reg(REG_BRAKE, 16'd0);
    write_reg(REG_TOP, 16'd10);
    write_reg(REG_CURVE, 16'd100);
    write_reg(REG_STRAIGHT, 16'd0);
    write_reg(REG_RAMP, 16'd0);
    write_reg(REG_SPIN, 16'd0);
    send_word(8'h01); send_word(8'h0C); send_word(8'h80); send_word(8'h00);
    drain();

    // random track runs across several settings
    for (int ph = 0; ph < 8; ph++) begin
      if (ph > 0) random_settings();
      if (ph == 3) hold_long = 1;
      repeat (14) track_run();
      drain();
    end

    if (fail_count == 0)
      $display("** line_follower_pd_speed_control: PASSED **");
    else
      $display("** line_follower_pd_speed_control: FAILED **");
    $finish;
  end

endmodule

>>> files.f
rtl/core/lfpd_pkg.sv
rtl/core/line_follower_pd_speed_control.sv
dv/lfpd_checker.sv
dv/tb_top.sv
